### rtl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// Used by the channel interfaces, the heap sequencer and the top level.
package mhpq_pkg;

  // Fixed widths of the request and response payload fields.
  localparam int KEY_IN_W    = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  // Command codes carried by a request.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes reported with every response.
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_LAST,
    S_SIB,
    S_MOVE,
    S_PLACE,
    S_FINISH
  } seq_state_t;

  // One request as handed to the sequencer.
  typedef struct packed {
    logic                       command;
    logic signed [KEY_IN_W-1:0] value;
  } req_t;

  // One response as produced by the sequencer.
  typedef struct packed {
    status_t                    status;
    logic signed [KEY_IN_W-1:0] removed_value;
    logic signed [KEY_IN_W-1:0] top_value;
    logic [COUNT_OUT_W-1:0]     count;
    logic                       is_empty_flag;
    logic                       is_full_flag;
  } rsp_t;

endpackage

### rtl/mhpq_ifs.sv
// Valid/ready channel interfaces for requests and responses of the heap queue.
// Depends on mhpq_pkg for the payload widths.
interface mhpq_req_if import mhpq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [KEY_IN_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [KEY_IN_W-1:0] removed_value;
  logic signed [KEY_IN_W-1:0] top_value;
  logic [COUNT_OUT_W-1:0]     count;
  logic                       is_empty_flag;
  logic                       is_full_flag;

  modport source (output valid, status, removed_value, top_value, count, is_empty_flag,
                  is_full_flag, input ready);
  modport sink (input valid, status, removed_value, top_value, count, is_empty_flag,
                is_full_flag, output ready);
endinterface

### rtl/mhpq_cmp.sv
// Shared signed key comparator of the heap queue.
// Depends on nothing but its width parameter; the sequencer steers its operands.
module mhpq_cmp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         lt
);

  // Signed less-than; every key comparison in the sifts is derived from this one result.
  assign lt = (a < b);

endmodule

### rtl/mhpq_seq.sv
// Heap sequencer: key memory, element count, root copy and the sift state machine.
// Depends on mhpq_pkg and on mhpq_cmp, the one comparator shared by all steps.
module mhpq_seq import mhpq_pkg::*; #(
  parameter int NODE_SLOTS = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  input  logic out_free,
  output logic idle,
  output logic done,
  output rsp_t rsp
);

  localparam int AW = $clog2(NODE_SLOTS);
  localparam logic [AW-1:0] CAP  = AW'(NODE_SLOTS - 1);
  localparam logic [AW-1:0] ROOT = AW'(1);

  // Key memory; slot 0 is never used.
  logic signed [DATA_WIDTH-1:0] mem [NODE_SLOTS];

  seq_state_t state, state_next;
  logic [AW-1:0] count, count_next;
  logic [AW-1:0] pos, pos_next;
  logic [AW-1:0] sel_idx, sel_idx_next;
  logic signed [DATA_WIDTH-1:0] key, key_next;
  logic signed [DATA_WIDTH-1:0] sel, sel_next;
  logic signed [DATA_WIDTH-1:0] removed, removed_next;
  logic signed [DATA_WIDTH-1:0] root;
  status_t status, status_next;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic signed [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]                ra, rb;
  logic signed [DATA_WIDTH-1:0] rd_a, rd_b;

  logic signed [DATA_WIDTH-1:0] cmp_a, cmp_b;
  logic                         cmp_lt;

  logic signed [DATA_WIDTH-1:0] in_key;
  logic [AW-1:0]                down_p;
  logic [AW:0]                  down_child;
  logic                         down_go;
  logic [AW:0]                  cur_child;
  logic                         take_b;

  mhpq_cmp #(.DATA_WIDTH(DATA_WIDTH)) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  // The incoming key is the signed request value resized to the stored width.
  assign in_key = DATA_WIDTH'(req.value);

  // Child position for the next step down, from the current or the chosen parent.
  assign down_p     = (state == S_MOVE) ? sel_idx : pos;
  assign down_child = {down_p, 1'b0};
  assign down_go    = (down_child <= {1'b0, count});
  assign cur_child  = {pos, 1'b0};
  assign take_b     = cmp_lt && (cur_child < {1'b0, count});

  // Memory with one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // Copy of slot 1, so the maximum is always at hand.
  always_ff @(posedge clk) begin
    if (we && (waddr == ROOT)) begin
      root <= wdata;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    sel_idx <= sel_idx_next;
    key     <= key_next;
    sel     <= sel_next;
    removed <= removed_next;
    status  <= status_next;
  end

  // Next state, memory access and comparator steering.
  always_comb begin
    state_next   = state;
    count_next   = count;
    pos_next     = pos;
    sel_idx_next = sel_idx;
    key_next     = key;
    sel_next     = sel;
    removed_next = removed;
    status_next  = status;
    we           = 1'b0;
    waddr        = pos;
    wdata        = key;
    ra           = down_child[AW-1:0];
    rb           = {down_child[AW-1:1], 1'b1};
    cmp_a        = rd_a;
    cmp_b        = key;
    idle         = 1'b0;
    done         = 1'b0;

    case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          status_next  = STAT_DONE;
          removed_next = '0;
          if (req.command == CMD_INSERT) begin
            if (count == CAP) begin
              status_next = STAT_FULL;
              state_next  = S_FINISH;
            end else begin
              count_next = count + AW'(1);
              pos_next   = count + AW'(1);
              key_next   = in_key;
              if (count == '0) begin
                we         = 1'b1;
                waddr      = ROOT;
                wdata      = in_key;
                state_next = S_FINISH;
              end else begin
                ra         = (count + AW'(1)) >> 1;
                state_next = S_UP;
              end
            end
          end else begin
            if (count == '0) begin
              status_next = STAT_EMPTY;
              state_next  = S_FINISH;
            end else begin
              removed_next = root;
              count_next   = count - AW'(1);
              pos_next     = ROOT;
              ra           = count;
              state_next   = S_LAST;
            end
          end
        end
      end

      // Sift up: the parent is on rd_a; move it down while the key is greater.
      S_UP: begin
        cmp_a = rd_a;
        cmp_b = key;
        we    = 1'b1;
        waddr = pos;
        if (cmp_lt) begin
          wdata    = rd_a;
          pos_next = pos >> 1;
          if ((pos >> 1) > ROOT) begin
            ra = pos >> 2;
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          wdata      = key;
          state_next = S_FINISH;
        end
      end

      // The last key is on rd_a; start the sift down from the root.
      S_LAST: begin
        key_next = rd_a;
        if (count == '0) begin
          state_next = S_FINISH;
        end else if (down_go) begin
          state_next = S_SIB;
        end else begin
          we         = 1'b1;
          waddr      = ROOT;
          wdata      = rd_a;
          state_next = S_FINISH;
        end
      end

      // Both children are on the read ports; pick the larger, the left on a tie.
      S_SIB: begin
        cmp_a        = rd_a;
        cmp_b        = rd_b;
        sel_next     = take_b ? rd_b : rd_a;
        sel_idx_next = take_b ? {cur_child[AW-1:1], 1'b1} : cur_child[AW-1:0];
        state_next   = S_MOVE;
      end

      // Stop when the key is not below the chosen child, else pull the child up.
      S_MOVE: begin
        cmp_a = key;
        cmp_b = sel;
        we    = 1'b1;
        waddr = pos;
        if (cmp_lt) begin
          wdata    = sel;
          pos_next = sel_idx;
          if (down_go) begin
            state_next = S_SIB;
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          wdata      = key;
          state_next = S_FINISH;
        end
      end

      S_PLACE: begin
        we         = 1'b1;
        waddr      = pos;
        wdata      = key;
        state_next = S_FINISH;
      end

      // Hold the response until the output register can take it.
      S_FINISH: begin
        done = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Response fields describe the heap after the operation.
  always_comb begin
    rsp.status        = status;
    rsp.removed_value = KEY_IN_W'(removed);
    rsp.top_value     = (count != '0) ? KEY_IN_W'(root) : '0;
    rsp.count         = COUNT_OUT_W'(count);
    rsp.is_empty_flag = (count == '0);
    rsp.is_full_flag  = (count == CAP);
  end

endmodule

### rtl/max_heap_priority_queue_top.sv
// Max-heap priority queue: request handshake, response register and checks.
// Depends on mhpq_pkg, mhpq_ifs and mhpq_seq.
//
// Usage: each request on req_ch carries a command (0 = insert value, 1 = remove
// the maximum) and a signed value. Each request gives exactly one response on
// rsp_ch with a status (done, insert dropped because full, remove on empty),
// the removed maximum, the new maximum, the element count and empty/full flags.
// The heap holds up to NODE_SLOTS-1 keys of DATA_WIDTH bits.
//
// Throughput: one request at a time; req_ch.ready is high only while the sequencer
// is idle. An insert takes longer for each level it rises, and a remove for each
// level it sinks, since each level of a remove needs a read of both children from
// the key memory and two uses of the one comparator. The response then passes
// through the output register to rsp_ch.
//
// Reset empties the heap at once (count zero, no clearing pass). When the
// receiver stalls, the response waits in the output register and one more
// request may be accepted; its response then waits in the sequencer.
module max_heap_priority_queue_top import mhpq_pkg::*; #(
  parameter int NODE_SLOTS = 128,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  mhpq_req_if.sink   req_ch,
  mhpq_rsp_if.source rsp_ch
);

  logic seq_idle;
  logic seq_done;
  logic out_free;
  logic start;
  logic out_valid;
  req_t req;
  rsp_t seq_rsp;
  rsp_t out_q;

  mhpq_seq #(
    .NODE_SLOTS (NODE_SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .out_free (out_free),
    .idle     (seq_idle),
    .done     (seq_done),
    .rsp      (seq_rsp)
  );

  // Request side: accept only while the sequencer is idle.
  assign req_ch.ready = seq_idle;
  assign start        = req_ch.valid && seq_idle;
  assign req.command  = req_ch.command;
  assign req.value    = req_ch.value;

  // Response register; it is free when empty or being taken this cycle.
  assign out_free = !out_valid || rsp_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_done && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done && out_free) begin
      out_q <= seq_rsp;
    end
  end

  assign rsp_ch.valid         = out_valid;
  assign rsp_ch.status        = out_q.status;
  assign rsp_ch.removed_value = out_q.removed_value;
  assign rsp_ch.top_value     = out_q.top_value;
  assign rsp_ch.count         = out_q.count;
  assign rsp_ch.is_empty_flag = out_q.is_empty_flag;
  assign rsp_ch.is_full_flag  = out_q.is_full_flag;

  // A request occupies the sequencer, so none is accepted in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
    else $error("request accepted while the sequencer was still busy");

  // A finished response that cannot move on stays put in the sequencer.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (seq_done && !out_free) |=> (seq_done && $stable(seq_rsp)))
    else $error("stalled response changed or vanished");

  // A dropped insert happens only on a full heap and removes nothing.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (rsp_ch.valid && (rsp_ch.status == STAT_FULL)) |->
      (rsp_ch.is_full_flag && (rsp_ch.removed_value == '0)))
    else $error("insert dropped while the heap was not full");

  // A remove on an empty heap returns zeros and leaves the heap empty.
  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (rsp_ch.valid && (rsp_ch.status == STAT_EMPTY)) |->
      (rsp_ch.is_empty_flag && (rsp_ch.removed_value == '0) && (rsp_ch.top_value == '0)))
    else $error("remove on empty heap reported data");

endmodule

### tb/max_heap_priority_queue_top_tb.sv
// Self-checking testbench for the max-heap priority queue top level.
// Needs mhpq_pkg, the channel interfaces in mhpq_ifs and the block itself;
// a shadow heap predicts every response and random stalls hit both channels.
module max_heap_priority_queue_top_tb;
  import mhpq_pkg::*;

  localparam int HEAP_SLOTS   = 128;
  localparam int CAPACITY     = HEAP_SLOTS - 1;
  localparam int RANDOM_ITEMS = 850;

  // Shadow copy of the heap and the responses it still owes.
  class heap_tracker;
    logic signed [KEY_IN_W-1:0] slots [HEAP_SLOTS];
    int unsigned                stored;
    rsp_t                       awaited_rsp [$];
    int                         errors;

    function new();
      stored = 0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int pending();
      return awaited_rsp.size();
    endfunction

    // Apply one accepted request to the shadow heap and queue its response.
    function void note_request(logic command, logic signed [KEY_IN_W-1:0] value);
      rsp_t                       r;
      int                         pos;
      int                         child;
      bit                         settled;
      logic signed [KEY_IN_W-1:0] last;
      r = '0;
      r.status = STAT_DONE;
      if (command == CMD_INSERT) begin
        if (stored >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          // Sift up past parents that are strictly smaller.
          stored++;
          pos = stored;
          while (pos > 1 && value > slots[pos / 2]) begin
            slots[pos] = slots[pos / 2];
            pos = pos / 2;
          end
          slots[pos] = value;
        end
      end else begin
        if (stored == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // Take the root and sink the last key toward the larger child.
          r.removed_value = slots[1];
          last = slots[stored];
          stored--;
          pos = 1;
          child = 2;
          settled = 1'b0;
          while (!settled && child <= stored) begin
            if (child < stored && slots[child] < slots[child + 1]) child++;
            if (last >= slots[child]) begin
              settled = 1'b1;
            end else begin
              slots[pos] = slots[child];
              pos = child;
              child = child * 2;
            end
          end
          slots[pos] = last;
        end
      end
      r.top_value     = (stored > 0) ? slots[1] : '0;
      r.count         = stored[COUNT_OUT_W-1:0];
      r.is_empty_flag = (stored == 0);
      r.is_full_flag  = (stored == CAPACITY);
      awaited_rsp.push_back(r);
    endfunction

    function void report_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted response with the oldest one awaited.
    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual status %0d top %0d",
                 $time, got.status, got.top_value);
        errors++;
      end else begin
        want = awaited_rsp.pop_front();
        report_field("status", longint'(want.status), longint'(got.status));
        report_field("removed_value", longint'(want.removed_value),
                     longint'(got.removed_value));
        report_field("top_value", longint'(want.top_value), longint'(got.top_value));
        report_field("count", longint'(want.count), longint'(got.count));
        report_field("is_empty_flag", longint'(want.is_empty_flag),
                     longint'(got.is_empty_flag));
        report_field("is_full_flag", longint'(want.is_full_flag),
                     longint'(got.is_full_flag));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   steady;

  heap_tracker tracker = new();

  mhpq_req_if req_ch ();
  mhpq_rsp_if rsp_ch ();

  max_heap_priority_queue_top #(
    .NODE_SLOTS(HEAP_SLOTS),
    .DATA_WIDTH(KEY_IN_W)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  always #5 clk = ~clk;

  // Response side: check each accepted response, then pick the next ready level.
  always @(posedge clk) begin
    rsp_t got;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status        = status_t'(rsp_ch.status);
        got.removed_value = rsp_ch.removed_value;
        got.top_value     = rsp_ch.top_value;
        got.count         = rsp_ch.count;
        got.is_empty_flag = rsp_ch.is_empty_flag;
        got.is_full_flag  = rsp_ch.is_full_flag;
        tracker.check_response(got);
      end
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 9);
    end
  end

  // Keys lean toward small values so that equal keys are common.
  function automatic logic signed [KEY_IN_W-1:0] pick_key();
    logic signed [KEY_IN_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: k = $signed($urandom_range(0, 8)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0: k = 32'sh7fffffff;
          1: k = 32'sh80000000;
          2: k = '0;
          default: k = -1;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(logic command, logic signed [KEY_IN_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 9) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= command;
    req_ch.value   <= (command == CMD_REMOVE) ? logic'($urandom) ? pick_key() : '0 : value;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(command, value);
  endtask

  // Stop offering requests until every awaited response has arrived.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic send_insert(logic signed [KEY_IN_W-1:0] value);
    send_request(CMD_INSERT, value);
  endtask

  task automatic send_remove();
    send_request(CMD_REMOVE, '0);
  endtask

  initial begin
    int sent;
    int seg;
    int span;
    rst            <= 1'b1;
    steady         = 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_INSERT;
    req_ch.value   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: remove on empty, extreme keys, equal keys, drain past empty.
    send_remove();
    send_insert('0);
    send_insert(32'sh7fffffff);
    send_insert(32'sh80000000);
    send_insert(-1);
    send_insert(32'sh7fffffff);
    send_insert(5);
    send_insert(5);
    send_insert(1);
    send_insert(5);
    send_insert(32'sh80000000);
    repeat (11) send_remove();
    drain_responses();

    // Random: mixed traffic, fill past full, drain past empty, in turn.
    sent = 0;
    seg = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (seg == 4);
      case (seg % 3)
        0: begin
          span = $urandom_range(20, 60);
          repeat (span) begin
            if ($urandom_range(0, 1) == 0) send_insert(pick_key());
            else send_remove();
            sent++;
          end
        end
        1: begin
          while (tracker.stored < CAPACITY) begin
            if ($urandom_range(0, 99) < 90) send_insert(pick_key());
            else send_remove();
            sent++;
          end
          span = $urandom_range(1, 4);
          repeat (span) begin
            send_insert(pick_key());
            sent++;
          end
        end
        default: begin
          while (tracker.stored > 0) begin
            if ($urandom_range(0, 99) < 90) send_remove();
            else send_insert(pick_key());
            sent++;
          end
          span = $urandom_range(1, 4);
          repeat (span) begin
            send_remove();
            sent++;
          end
        end
      endcase
      if (seg == 2) drain_responses();
      seg++;
    end
    steady = 1'b0;

    // Let the last responses through, then a few idle cycles.
    drain_responses();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("max_heap_priority_queue_top_tb: done, clean");
    end else begin
      $display("max_heap_priority_queue_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("max_heap_priority_queue_top_tb: done, errors");
    $finish;
  end

endmodule
